[hdl/slip_reply_packet_parser_core_defines.svh]
// Assertion macros shared by the parser core
`ifndef SLIP_REPLY_PACKET_PARSER_CORE_DEFINES_SVH
`define SLIP_REPLY_PACKET_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define SRPP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define SRPP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/slip_rpp_pkg.sv]
package slip_rpp_pkg;

  // Default build parameters
  localparam int unsigned MAX_DESC_DEF = 16;
  localparam int unsigned LEN_BITS_DEF = 16;

  // SLIP framing bytes
  localparam logic [7:0] SLIP_DELIM     = 8'hC0;
  localparam logic [7:0] SLIP_ESC       = 8'hDB;
  localparam logic [7:0] SLIP_ESC_DELIM = 8'hDC;
  localparam logic [7:0] SLIP_TFESC     = 8'hDD;

  // Descriptor layout
  localparam int unsigned CHAIN_BIT_POS = 7;
  localparam int unsigned KIND_BITS     = 3;

  // Header byte positions
  localparam int unsigned HDR_DEVICE  = 0;
  localparam int unsigned HDR_COMMAND = 1;
  localparam int unsigned HDR_LEN_LO  = 2;
  localparam int unsigned HDR_LEN_HI  = 3;
  localparam int unsigned HDR_SUM     = 4;
  localparam int unsigned HDR_DESC    = 5;
  localparam int unsigned HDR_BYTES   = 6;

  // Largest parameter byte count one descriptor may ask for
  localparam int unsigned MAX_PARAM_PER_DESC = 4;

  // Per-kind field size and field count
  localparam logic [2:0] FIELD_SIZE  [8] = '{3'd0, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd4};
  localparam logic [2:0] FIELD_COUNT [8] = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd1, 3'd2, 3'd1};

  // Frame status codes, first failing check wins
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_LEN       = 3'd2,
    ST_CSUM      = 3'd3,
    ST_TOO_MANY  = 3'd4,
    ST_CHAIN     = 3'd5,
    ST_PARAMS    = 3'd6
  } status_e;

  // Decoder to checker events for one raw beat
  typedef struct packed {
    logic       clear;     // frame opens or closes: wipe packet state
    logic       close;     // delimiter closing an open frame
    logic       data_vld;  // one decoded byte
    logic [7:0] data;
  } dec_t;

  // One result beat
  typedef struct packed {
    logic        vld;
    logic        frame_end;
    logic [7:0]  payload;
    logic [7:0]  device;
    logic [7:0]  command;
    status_e     status;
    logic [15:0] count;
  } res_t;

  // Parameter bytes a descriptor kind asks for
  function automatic logic [2:0] param_len(logic [KIND_BITS-1:0] kind);
    logic [5:0] p;
    p = 6'(FIELD_COUNT[kind]) * 6'(FIELD_SIZE[kind]);
    return p[2:0];
  endfunction

endpackage

[hdl/slip_reply_packet_parser_core.sv]
// SLIP reply deframer with in-stream packet checks.
// An accepted input beat is held in the input register, then moved into the result register by a step.
// Throughput: one raw byte per cycle; single-entry input and result registers, so the
// input side stalls only while a result is held by out_stall_i.
// Reset (rst_ni low, asynchronous): both registers empty, frame hunt restarts,
// all packet state cleared.
`include "slip_reply_packet_parser_core_defines.svh"

module slip_reply_packet_parser_core import slip_rpp_pkg::*; #(
  parameter int unsigned MAX_DESCRIPTORS = MAX_DESC_DEF,
  parameter int unsigned LENGTH_BITS     = LEN_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        frame_end_o,
  output logic [7:0]  payload_byte_o,
  output logic [7:0]  device_id_o,
  output logic [7:0]  command_code_o,
  output logic [2:0]  status_code_o,
  output logic [15:0] payload_count_o
);

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       step;
  logic       in_take;
  dec_t       dec;
  res_t       res;
  res_t       out_q;

  // Processing step moves the held beat into the result register
  assign step       = in_vld_q && (!out_q.vld || !out_stall_i);
  assign in_stall_o = in_vld_q && !step;
  assign in_take    = in_valid_i && !in_stall_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (step) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= rx_byte_i;
    end
  end

  slip_rpp_decoder u_decoder (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .dec_o  (dec)
  );

  slip_rpp_checker #(
    .MAX_DESCRIPTORS (MAX_DESCRIPTORS),
    .LENGTH_BITS     (LENGTH_BITS)
  ) u_checker (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .dec_i  (dec),
    .res_o  (res)
  );

  // Result register: loaded per step, valid dropped once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else if (step) begin
      out_q <= res;
    end else if (!out_stall_i) begin
      out_q.vld <= 1'b0;
    end
  end

  assign out_valid_o     = out_q.vld;
  assign frame_end_o     = out_q.frame_end;
  assign payload_byte_o  = out_q.payload;
  assign device_id_o     = out_q.device;
  assign command_code_o  = out_q.command;
  assign status_code_o   = out_q.status;
  assign payload_count_o = out_q.count;

  // Checks
  `SRPP_ASSERT_NOW(a_stall_cause, clk_i, rst_ni, in_stall_o,
    in_vld_q && out_q.vld && out_stall_i, "input stalled without a blocked result")
  `SRPP_ASSERT_NOW(a_status_range, clk_i, rst_ni, out_valid_o && frame_end_o,
    payload_byte_o == 8'd0 && status_code_o <= ST_PARAMS, "bad status beat")
  `SRPP_ASSERT_NOW(a_payload_clean, clk_i, rst_ni, out_valid_o && !frame_end_o,
    device_id_o == 8'd0 && command_code_o == 8'd0 && status_code_o == ST_OK &&
    payload_count_o == 16'd0, "payload beat carries status fields")
  `SRPP_ASSERT_NEXT(a_step_drains, clk_i, rst_ni, step && !in_take, !in_vld_q,
    "input register not drained after step")

endmodule

[hdl/slip_rpp_decoder.sv]
module slip_rpp_decoder import slip_rpp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output dec_t       dec_o
);

  logic in_frame_q, in_frame_d;
  logic esc_q, esc_d;

  // SLIP unescape and framing
  always_comb begin
    in_frame_d    = in_frame_q;
    esc_d         = esc_q;
    dec_o         = '0;
    dec_o.data    = byte_i;
    if (!in_frame_q) begin
      // hunt for the first delimiter
      if (byte_i == SLIP_DELIM) begin
        in_frame_d  = 1'b1;
        dec_o.clear = 1'b1;
      end
    end else if (esc_q) begin
      // byte after an escape is always consumed
      esc_d = 1'b0;
      if (byte_i == SLIP_ESC_DELIM) begin
        dec_o.data_vld = 1'b1;
        dec_o.data     = SLIP_DELIM;
      end else if (byte_i == SLIP_TFESC) begin
        dec_o.data_vld = 1'b1;
        dec_o.data     = SLIP_ESC;
      end
    end else if (byte_i == SLIP_DELIM) begin
      dec_o.close = 1'b1;
      dec_o.clear = 1'b1;
    end else if (byte_i == SLIP_ESC) begin
      esc_d = 1'b1;
    end else begin
      dec_o.data_vld = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      esc_q      <= 1'b0;
    end else if (step_i) begin
      in_frame_q <= in_frame_d;
      esc_q      <= esc_d;
    end
  end

endmodule

[hdl/slip_rpp_checker.sv]
module slip_rpp_checker import slip_rpp_pkg::*; #(
  parameter int unsigned MAX_DESCRIPTORS = MAX_DESC_DEF,
  parameter int unsigned LENGTH_BITS     = LEN_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic step_i,
  input  dec_t dec_i,
  output res_t res_o
);

  localparam int unsigned CW = LENGTH_BITS + 1;
  localparam int unsigned DW = (MAX_DESCRIPTORS > 1) ? $clog2(MAX_DESCRIPTORS) : 1;
  localparam int unsigned PW = $clog2(MAX_PARAM_PER_DESC * MAX_DESCRIPTORS + 1);

  logic [CW-1:0]          count_q, count_d;
  logic [7:0]             sum_q, sum_d;
  logic [7:0]             rx_sum_q, rx_sum_d;
  logic [7:0]             dev_q, dev_d;
  logic [7:0]             cmd_q, cmd_d;
  logic [LENGTH_BITS-1:0] len_q, len_d;
  logic [DW-1:0]          desc_q, desc_d;
  logic                   chain_q, chain_d;
  logic                   too_many_q, too_many_d;
  logic [PW-1:0]          param_q, param_d;
  logic [15:0]            seen_q, seen_d;

  logic [8:0]             sum_raw;
  logic [15:0]            len_full;
  logic [DW-1:0]          desc_cur;
  logic [DW:0]            desc_inc;
  logic                   is_payload;
  status_e                status;

  // Status of the frame being closed
  always_comb begin
    if (count_q < CW'(HDR_BYTES)) begin
      status = ST_SHORT;
    end else if (count_q != {1'b0, len_q}) begin
      status = ST_LEN;
    end else if (sum_q != rx_sum_q) begin
      status = ST_CSUM;
    end else if (too_many_q) begin
      status = ST_TOO_MANY;
    end else if (chain_q) begin
      status = ST_CHAIN;
    end else if (param_q != '0) begin
      status = ST_PARAMS;
    end else begin
      status = ST_OK;
    end
  end

  // Per-byte header, descriptor and parameter tracking
  always_comb begin
    count_d    = count_q;
    sum_d      = sum_q;
    rx_sum_d   = rx_sum_q;
    dev_d      = dev_q;
    cmd_d      = cmd_q;
    len_d      = len_q;
    desc_d     = desc_q;
    chain_d    = chain_q;
    too_many_d = too_many_q;
    param_d    = param_q;
    seen_d     = seen_q;
    is_payload = 1'b0;
    desc_cur   = desc_q;
    len_full   = {dec_i.data, len_q[7:0]};

    // end-around-carry sum, checksum byte counted as zero
    sum_raw = {1'b0, sum_q} + ((count_q == CW'(HDR_SUM)) ? 9'd0 : {1'b0, dec_i.data});
    desc_inc = '0;

    if (dec_i.clear) begin
      count_d    = '0;
      sum_d      = '0;
      rx_sum_d   = '0;
      dev_d      = '0;
      cmd_d      = '0;
      len_d      = '0;
      desc_d     = '0;
      chain_d    = 1'b0;
      too_many_d = 1'b0;
      param_d    = '0;
      seen_d     = '0;
    end else if (dec_i.data_vld) begin
      sum_d = sum_raw[7:0] + {7'd0, sum_raw[8]};
      if (count_q == CW'(HDR_DEVICE)) begin
        dev_d = dec_i.data;
      end else if (count_q == CW'(HDR_COMMAND)) begin
        cmd_d = dec_i.data;
      end else if (count_q == CW'(HDR_LEN_LO)) begin
        len_d = LENGTH_BITS'(dec_i.data);
      end else if (count_q == CW'(HDR_LEN_HI)) begin
        len_d = len_full[LENGTH_BITS-1:0];
      end else if (count_q == CW'(HDR_SUM)) begin
        rx_sum_d = dec_i.data;
      end else if (count_q == CW'(HDR_DESC) || (!too_many_q && chain_q)) begin
        // chained descriptors advance the count before being taken
        if (count_q != CW'(HDR_DESC)) begin
          desc_cur = desc_q + DW'(1);
        end
        desc_d   = desc_cur;
        param_d  = param_q + PW'(param_len(dec_i.data[KIND_BITS-1:0]));
        chain_d  = dec_i.data[CHAIN_BIT_POS];
        desc_inc = {1'b0, desc_cur} + (DW+1)'(1);
        if (dec_i.data[CHAIN_BIT_POS] && desc_inc >= (DW+1)'(MAX_DESCRIPTORS)) begin
          too_many_d = 1'b1;
          chain_d    = 1'b0;
        end
      end else if (too_many_q) begin
        // frame already failed, nothing more to parse
      end else if (param_q != '0) begin
        param_d = param_q - PW'(1);
      end else begin
        is_payload = 1'b1;
        if (seen_q != 16'hFFFF) begin
          seen_d = seen_q + 16'd1;
        end
      end
      if (count_q != '1) begin
        count_d = count_q + CW'(1);
      end
    end
  end

  // Result for this beat
  always_comb begin
    res_o = '0;
    if (dec_i.close) begin
      res_o.vld       = (count_q != '0);
      res_o.frame_end = 1'b1;
      res_o.device    = dev_q;
      res_o.command   = cmd_q;
      res_o.status    = status;
      res_o.count     = seen_q;
    end else begin
      res_o.vld     = is_payload;
      res_o.payload = dec_i.data;
      res_o.status  = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      sum_q      <= '0;
      rx_sum_q   <= '0;
      dev_q      <= '0;
      cmd_q      <= '0;
      len_q      <= '0;
      desc_q     <= '0;
      chain_q    <= 1'b0;
      too_many_q <= 1'b0;
      param_q    <= '0;
      seen_q     <= '0;
    end else if (step_i) begin
      count_q    <= count_d;
      sum_q      <= sum_d;
      rx_sum_q   <= rx_sum_d;
      dev_q      <= dev_d;
      cmd_q      <= cmd_d;
      len_q      <= len_d;
      desc_q     <= desc_d;
      chain_q    <= chain_d;
      too_many_q <= too_many_d;
      param_q    <= param_d;
      seen_q     <= seen_d;
    end
  end

endmodule

[verif/tb_slip_reply_packet_parser_core.sv]
module tb_slip_reply_packet_parser_core;
  import slip_rpp_pkg::*;

  localparam int CNT_W        = LEN_BITS_DEF + 1;
  localparam int RANDOM_ITEMS = 1400;
  localparam int LONG_PAYLOAD = 200;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_TAIL   = 6;
  localparam int CYCLE_LIMIT  = 6000000;

  // parameter bytes asked for by each descriptor kind (count * size)
  localparam int KIND_PARAM_BYTES [8] = '{0, 1, 2, 3, 4, 2, 4, 4};

  typedef struct packed {
    logic        frame_end;
    logic [7:0]  payload;
    logic [7:0]  device;
    logic [7:0]  command;
    status_e     status;
    logic [15:0] count;
  } reply_t;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_e;

  // Deframer/checker predictor and store of expected replies
  class reply_scoreboard;
    reply_t           expected_replies[$];
    int               mismatches;
    bit               in_frame;
    bit               esc_pend;
    bit               chain_on;
    bit               too_many;
    logic [CNT_W-1:0] dec_count;
    logic [7:0]       run_sum;
    logic [7:0]       rcv_sum;
    logic [7:0]       dev;
    logic [7:0]       cmd;
    logic [LEN_BITS_DEF-1:0] hdr_len;
    logic [4:0]       desc_total;
    logic [6:0]       params_left;
    logic [15:0]      payload_seen;

    function new();
      mismatches = 0;
      in_frame   = 1'b0;
      clear_frame();
    endfunction

    function void clear_frame();
      esc_pend     = 1'b0;
      chain_on     = 1'b0;
      too_many     = 1'b0;
      dec_count    = '0;
      run_sum      = '0;
      rcv_sum      = '0;
      dev          = '0;
      cmd          = '0;
      hdr_len      = '0;
      desc_total   = '0;
      params_left  = '0;
      payload_seen = '0;
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    function void take_descriptor(logic [7:0] d);
      params_left += 7'(KIND_PARAM_BYTES[d[2:0]]);
      chain_on = d[CHAIN_BIT_POS];
      // chain asks for one more than the table holds
      if (chain_on && int'(desc_total) + 1 >= MAX_DESC_DEF) begin
        too_many = 1'b1;
        chain_on = 1'b0;
      end
    endfunction

    // one decoded byte: header, descriptor chain, parameters, then payload
    function void absorb_decoded(logic [7:0] b);
      logic [8:0]       s;
      logic [CNT_W-1:0] i;
      reply_t           r;
      i = dec_count;
      s = run_sum + ((i == HDR_SUM) ? 8'd0 : b);
      run_sum = s[7:0] + {7'd0, s[8]};
      if (i == HDR_DEVICE) begin
        dev = b;
      end else if (i == HDR_COMMAND) begin
        cmd = b;
      end else if (i == HDR_LEN_LO) begin
        hdr_len = LEN_BITS_DEF'(b);
      end else if (i == HDR_LEN_HI) begin
        hdr_len = LEN_BITS_DEF'({b, hdr_len[7:0]});
      end else if (i == HDR_SUM) begin
        rcv_sum = b;
      end else if (i == HDR_DESC) begin
        take_descriptor(b);
      end else if (too_many) begin
        // frame already failed, nothing left to parse
      end else if (chain_on) begin
        desc_total = desc_total + 5'd1;
        take_descriptor(b);
      end else if (params_left != 0) begin
        params_left = params_left - 7'd1;
      end else begin
        r = '0;
        r.payload = b;
        r.status  = ST_OK;
        expected_replies.push_back(r);
        if (payload_seen != 16'hFFFF) payload_seen = payload_seen + 16'd1;
      end
      if (dec_count != '1) dec_count = dec_count + 1'b1;
    endfunction

    // note one accepted line byte
    function void note_input(logic [7:0] b);
      reply_t r;
      if (!in_frame) begin
        if (b == SLIP_DELIM) begin
          in_frame = 1'b1;
          clear_frame();
        end
      end else if (esc_pend) begin
        esc_pend = 1'b0;
        if (b == SLIP_ESC_DELIM) absorb_decoded(SLIP_DELIM);
        else if (b == SLIP_TFESC) absorb_decoded(SLIP_ESC);
      end else if (b == SLIP_DELIM) begin
        // closing delimiter: status unless the frame was empty
        if (dec_count != 0) begin
          r = '0;
          r.frame_end = 1'b1;
          r.device    = dev;
          r.command   = cmd;
          r.count     = payload_seen;
          if (dec_count < HDR_BYTES) r.status = ST_SHORT;
          else if (dec_count != {1'b0, hdr_len}) r.status = ST_LEN;
          else if (run_sum != rcv_sum) r.status = ST_CSUM;
          else if (too_many) r.status = ST_TOO_MANY;
          else if (chain_on) r.status = ST_CHAIN;
          else if (params_left != 0) r.status = ST_PARAMS;
          else r.status = ST_OK;
          expected_replies.push_back(r);
        end
        clear_frame();
      end else if (b == SLIP_ESC) begin
        esc_pend = 1'b1;
      end else begin
        absorb_decoded(b);
      end
    endfunction

    // compare one accepted result beat with the oldest expectation
    function void check_result(reply_t got);
      reply_t want;
      if (expected_replies.size() == 0) begin
        $error("result beat with nothing expected: %h", got);
        mismatches++;
        return;
      end
      want = expected_replies.pop_front();
      if (got.frame_end !== want.frame_end) begin
        $error("frame_end: expected %0d, got %0d", want.frame_end, got.frame_end);
        mismatches++;
      end
      if (got.payload !== want.payload) begin
        $error("payload_byte: expected %0h, got %0h", want.payload, got.payload);
        mismatches++;
      end
      if (got.device !== want.device) begin
        $error("device_id: expected %0h, got %0h", want.device, got.device);
        mismatches++;
      end
      if (got.command !== want.command) begin
        $error("command_code: expected %0h, got %0h", want.command, got.command);
        mismatches++;
      end
      if (got.status !== want.status) begin
        $error("status_code: expected %0d, got %0d", want.status, got.status);
        mismatches++;
      end
      if (got.count !== want.count) begin
        $error("payload_count: expected %0d, got %0d", want.count, got.count);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        frame_end_o;
  logic [7:0]  payload_byte_o;
  logic [7:0]  device_id_o;
  logic [7:0]  command_code_o;
  logic [2:0]  status_code_o;
  logic [15:0] payload_count_o;

  reply_scoreboard sb;
  logic [7:0]      frame_q[$];
  int              burst_left;
  int              gap_max;
  int              accepted_items;
  bit              hold_req;

  slip_reply_packet_parser_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .frame_end_o     (frame_end_o),
    .payload_byte_o  (payload_byte_o),
    .device_id_o     (device_id_o),
    .command_code_o  (command_code_o),
    .status_code_o   (status_code_o),
    .payload_count_o (payload_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("TEST FAILED");
    $finish;
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(reply_t'({frame_end_o, payload_byte_o, device_id_o, command_code_o,
                                status_code_o, payload_count_o}));
    end
  end

  // receiver: stall pattern of its own, plus long hold-offs on request
  initial begin : receiver
    rx_mode_e mode;
    int       left;
    int       phase;
    out_stall_i = 1'b0;
    mode  = RX_FREE;
    left  = 0;
    phase = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      if (left == 0) begin
        mode = rx_mode_e'($urandom_range(0, 3));
        left = $urandom_range(16, 128);
      end
      left--;
      phase++;
      case (mode)
        RX_FREE:     out_stall_i <= 1'b0;
        RX_LIGHT:    out_stall_i <= ($urandom_range(0, 3) == 0);
        RX_HEAVY:    out_stall_i <= ($urandom_range(0, 9) < 6);
        default:     out_stall_i <= (phase % 4 == 3);
      endcase
    end
  end

  // one raw line beat, sent in bursts with random gaps
  task automatic send_raw(input logic [7:0] b);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(b);
    burst_left--;
    accepted_items++;
  endtask

  // SLIP-encode one decoded byte
  task automatic send_decoded(input logic [7:0] b);
    if (b == SLIP_DELIM) begin
      send_raw(SLIP_ESC);
      send_raw(SLIP_ESC_DELIM);
    end else if (b == SLIP_ESC) begin
      send_raw(SLIP_ESC);
      send_raw(SLIP_TFESC);
    end else begin
      send_raw(b);
    end
  endtask

  // send frame_q and its closing delimiter, bad escapes mixed in at bad_pct
  task automatic send_frame(input int bad_pct);
    logic [7:0] junk;
    foreach (frame_q[k]) begin
      if ($urandom_range(0, 99) < bad_pct) begin
        junk = 8'($urandom);
        if (junk == SLIP_ESC_DELIM || junk == SLIP_TFESC) junk = junk ^ 8'h10;
        send_raw(SLIP_ESC);
        send_raw((k % 2) ? SLIP_DELIM : junk);
      end
      send_decoded(frame_q[k]);
    end
    send_raw(SLIP_DELIM);
  endtask

  task automatic pause_sender();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = 0;
  endtask

  // hold the sender until every expected result is out
  task automatic drain();
    pause_sender();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_TAIL) @(posedge clk_i);
  endtask

  // biased towards the framing bytes
  function automatic logic [7:0] line_byte();
    case ($urandom_range(0, 15))
      0:       return SLIP_DELIM;
      1:       return SLIP_ESC;
      default: return 8'($urandom);
    endcase
  endfunction

  // fill in length and end-around-carry checksum of frame_q
  function automatic void seal_frame();
    logic [15:0] len;
    logic [8:0]  s;
    logic [7:0]  acc;
    len = 16'(frame_q.size());
    if (frame_q.size() > HDR_LEN_HI) begin
      frame_q[HDR_LEN_LO] = len[7:0];
      frame_q[HDR_LEN_HI] = len[15:8];
    end
    acc = '0;
    foreach (frame_q[k]) begin
      if (k != HDR_SUM) begin
        s   = acc + frame_q[k];
        acc = s[7:0] + {7'd0, s[8]};
      end
    end
    if (frame_q.size() > HDR_SUM) frame_q[HDR_SUM] = acc;
  endfunction

  // header, descriptor chain, parameters and payload with random content
  function automatic void build_frame(int n_desc, int n_pay);
    logic [7:0] d;
    int         n_par;
    frame_q = '{8'($urandom), 8'($urandom), 8'h00, 8'h00, 8'h00};
    n_par = 0;
    for (int k = 0; k < n_desc; k++) begin
      d = 8'($urandom);
      d[CHAIN_BIT_POS] = (k < n_desc - 1);
      frame_q.push_back(d);
      if (k < MAX_DESC_DEF) n_par += KIND_PARAM_BYTES[d[2:0]];
    end
    repeat (n_par) frame_q.push_back(line_byte());
    repeat (n_pay) frame_q.push_back(line_byte());
    seal_frame();
  endfunction

  initial begin : stimulus
    int base;
    int frame_no;
    int n_desc;
    int n_pay;
    int pick;
    int cut;
    sb = new();
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    rx_byte_i  = 8'h00;
    hold_req   = 1'b0;
    burst_left = 0;
    gap_max    = 3;
    accepted_items = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // line noise before the first delimiter, escape included
    send_raw(8'h00);
    send_raw(8'hFF);
    send_raw(SLIP_ESC);
    send_raw(SLIP_DELIM);
    // empty frame
    send_raw(SLIP_DELIM);
    // good frame, payload at the byte extremes and escaped bytes
    frame_q = '{8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                SLIP_DELIM, SLIP_ESC, 8'h00, 8'hFF, SLIP_ESC_DELIM, SLIP_TFESC};
    seal_frame();
    send_frame(0);
    // descriptor kinds 1 to 7 chained, with their parameters
    frame_q = '{8'h11, 8'h22, 8'h00, 8'h00, 8'h00};
    for (int k = 1; k < 7; k++) frame_q.push_back(8'h80 | 8'(k));
    frame_q.push_back(8'h07);
    repeat (20 + 3) frame_q.push_back(line_byte());
    seal_frame();
    send_frame(0);
    // too many descriptors
    frame_q = '{8'h33, 8'h44, 8'h00, 8'h00, 8'h00};
    repeat (MAX_DESC_DEF + 1) frame_q.push_back(8'h80);
    frame_q.push_back(8'h00);
    frame_q.push_back(8'h5A);
    seal_frame();
    send_frame(0);
    // chain truncated
    frame_q = '{8'h55, 8'h66, 8'h00, 8'h00, 8'h00, 8'h81};
    seal_frame();
    send_frame(0);
    // parameters truncated
    frame_q = '{8'h77, 8'h88, 8'h00, 8'h00, 8'h00, 8'h07, 8'hAA, 8'hBB};
    seal_frame();
    send_frame(0);
    // checksum and length errors
    build_frame(1, 4);
    frame_q[HDR_SUM] = frame_q[HDR_SUM] ^ 8'h5A;
    send_frame(0);
    build_frame(2, 2);
    frame_q[HDR_LEN_HI] = frame_q[HDR_LEN_HI] ^ 8'h80;
    send_frame(0);
    // short frame
    frame_q = '{8'h12, 8'h34, 8'h56};
    send_frame(0);
    // bad escapes everywhere, escaped delimiters among them
    build_frame(2, 5);
    send_frame(100);
    // a frame of one escaped byte, then one of bad escapes only
    send_raw(SLIP_ESC);
    send_raw(SLIP_TFESC);
    send_raw(SLIP_DELIM);
    send_raw(SLIP_ESC);
    send_raw(8'h41);
    send_raw(SLIP_ESC);
    send_raw(SLIP_DELIM);
    send_raw(SLIP_DELIM);
    drain();

    // random frames, mostly well formed
    base = accepted_items;
    frame_no = 0;
    while (accepted_items - base < RANDOM_ITEMS) begin
      if (frame_no % 25 == 0) begin
        case ($urandom_range(0, 2))
          0:       gap_max = 0;
          1:       gap_max = 2;
          default: gap_max = 6;
        endcase
      end
      if (frame_no == 8 || frame_no == 24) hold_req = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        // raw noise
        repeat ($urandom_range(1, 12)) begin
          case ($urandom_range(0, 7))
            0:       send_raw(SLIP_DELIM);
            1:       send_raw(SLIP_ESC);
            2:       send_raw(SLIP_ESC_DELIM);
            3:       send_raw(SLIP_TFESC);
            default: send_raw(8'($urandom));
          endcase
        end
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 70) n_desc = $urandom_range(1, 3);
        else if (pick < 90) n_desc = $urandom_range(4, MAX_DESC_DEF);
        else n_desc = $urandom_range(MAX_DESC_DEF + 1, MAX_DESC_DEF + 3);
        n_pay = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 20);
        build_frame(n_desc, n_pay);
        pick = $urandom_range(0, 99);
        if (pick >= 55 && pick < 67) begin
          // cut short, header fields made to match the cut
          cut = $urandom_range(1, frame_q.size() - 1);
          while (frame_q.size() > cut) void'(frame_q.pop_back());
          seal_frame();
        end else if (pick >= 67 && pick < 77) begin
          frame_q[HDR_LEN_LO + $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
        end else if (pick >= 77 && pick < 87) begin
          frame_q[HDR_SUM] ^= 8'($urandom_range(1, 255));
        end
        send_frame((pick >= 87) ? 15 : 0);
      end
      if (frame_no % 50 == 49) drain();
      frame_no++;
    end

    // long payload run with random header bytes
    gap_max = 2;
    send_decoded(8'($urandom));
    send_decoded(8'($urandom));
    send_decoded(8'($urandom));
    send_decoded(8'($urandom));
    send_decoded(8'($urandom));
    send_decoded(8'h00);
    repeat (LONG_PAYLOAD) send_decoded(line_byte());
    send_raw(SLIP_DELIM);

    drain();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
